// ----- sv/dcik_pkg.sv -----
// ----------------------------------------------------------------------------
// dcik_pkg
// Shared types and constants for the delta carriage inverse kinematics block.
// ----------------------------------------------------------------------------
package dcik_pkg;

  localparam int LEN_W   = 22;
  localparam int POS_W   = 24;
  localparam int K_W     = 23;
  localparam int ZS_W    = 25;
  localparam int D_W     = 26;
  localparam int SQ_W    = 50;
  localparam int D2_W    = 51;
  localparam int RAD_W   = 2 * LEN_W;
  localparam int REM_W   = LEN_W + 3;
  localparam int NSTG    = LEN_W;
  localparam int H_W     = 27;
  localparam int NTWR    = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic signed [16:0] COEF_SIN  = 17'sd56754;
  localparam logic signed [40:0] HALF_ULP  = 41'sd32768;
  localparam int                 COEF_BITS = 16;

  localparam logic signed [POS_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] OUT_MIN = 24'sh800000;

  localparam logic [2:0] REG_ARM    = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PLAT   = 3'd2;
  localparam logic [2:0] REG_BASE   = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;

  localparam logic [LEN_W-1:0] ARM_RESET = 22'd58880;

  typedef struct packed {
    logic [LEN_W-1:0]        arm;
    logic [LEN_W-1:0]        height;
    logic [LEN_W-1:0]        plat;
    logic [LEN_W-1:0]        base;
    logic signed [LEN_W-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic signed [ZS_W-1:0] zsum;
    logic [NTWR-1:0]        mask;
  } side_t;

endpackage

// ----- sv/dcik_cfg.sv -----
// ----------------------------------------------------------------------------
// dcik_cfg
// APB-style register file holding the robot geometry.
// ----------------------------------------------------------------------------
module dcik_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dcik_pkg::ADDR_W-1:0]  paddr,
  input  logic [dcik_pkg::DATA_W-1:0]  pwdata,
  output logic [dcik_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output dcik_pkg::cfg_t               cfg
);

  dcik_pkg::cfg_t cfg_r;
  logic [2:0] idx;
  logic [dcik_pkg::LEN_W-1:0] wd;

  assign idx    = paddr[4:2];
  assign wd     = pwdata[dcik_pkg::LEN_W-1:0];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm    <= dcik_pkg::ARM_RESET;
      cfg_r.height <= '0;
      cfg_r.plat   <= '0;
      cfg_r.base   <= '0;
      cfg_r.offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        dcik_pkg::REG_ARM:    cfg_r.arm    <= wd;
        dcik_pkg::REG_HEIGHT: cfg_r.height <= wd;
        dcik_pkg::REG_PLAT:   cfg_r.plat   <= wd;
        dcik_pkg::REG_BASE:   cfg_r.base   <= wd;
        dcik_pkg::REG_OFFSET: cfg_r.offset <= $signed(wd);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dcik_pkg::REG_ARM:    prdata = {10'd0, cfg_r.arm};
      dcik_pkg::REG_HEIGHT: prdata = {10'd0, cfg_r.height};
      dcik_pkg::REG_PLAT:   prdata = {10'd0, cfg_r.plat};
      dcik_pkg::REG_BASE:   prdata = {10'd0, cfg_r.base};
      dcik_pkg::REG_OFFSET: prdata = {{10{cfg_r.offset[dcik_pkg::LEN_W-1]}}, cfg_r.offset};
      default:              prdata = '0;
    endcase
  end

endmodule

// ----- sv/dcik_front.sv -----
// ----------------------------------------------------------------------------
// dcik_front
// Four stages: tower offsets, joint-to-tower deltas, squares, reach test.
// ----------------------------------------------------------------------------
module dcik_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  dcik_pkg::cfg_t                     cfg,
  input  logic                               v_in,
  input  logic signed [dcik_pkg::POS_W-1:0]  x_in,
  input  logic signed [dcik_pkg::POS_W-1:0]  y_in,
  input  logic signed [dcik_pkg::POS_W-1:0]  z_in,
  output logic                               v_out,
  output logic [dcik_pkg::RAD_W-1:0]         rad_out [dcik_pkg::NTWR],
  output dcik_pkg::side_t                    side_out
);

  function automatic logic signed [dcik_pkg::ZS_W-1:0] ZS_W_ext(
    input logic signed [dcik_pkg::POS_W-1:0] v);
    return {v[dcik_pkg::POS_W-1], v};
  endfunction

  function automatic logic signed [dcik_pkg::ZS_W-1:0] ZS_W_off(
    input logic signed [dcik_pkg::LEN_W-1:0] v);
    return {{3{v[dcik_pkg::LEN_W-1]}}, v};
  endfunction

  // stage 1
  logic                               v1_r;
  logic signed [dcik_pkg::POS_W-1:0]  x1_r, y1_r;
  logic signed [dcik_pkg::ZS_W-1:0]   zs1_r;
  logic signed [dcik_pkg::K_W-1:0]    k1_r;
  logic signed [40:0]                 p1_r;
  logic signed [dcik_pkg::K_W-1:0]    k_nxt;

  assign k_nxt = $signed({1'b0, cfg.base}) - $signed({1'b0, cfg.plat});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= x_in;
      y1_r  <= y_in;
      zs1_r <= ZS_W_ext(z_in) + ZS_W_off(cfg.offset);
      k1_r  <= k_nxt;
      p1_r  <= 41'(k_nxt * dcik_pkg::COEF_SIN);
    end
  end

  // stage 2
  logic                             v2_r;
  logic signed [dcik_pkg::D_W-1:0]  dx2_r [dcik_pkg::NTWR];
  logic signed [dcik_pkg::D_W-1:0]  dy2_r [dcik_pkg::NTWR];
  logic signed [dcik_pkg::ZS_W-1:0] zs2_r;
  logic signed [40:0] hx, sy, sny, ka, xe, ye;

  always_comb begin
    ka  = 41'(k1_r);
    xe  = 41'(x1_r);
    ye  = 41'(y1_r);
    hx  = (41'sd1 - ka) >>> 1;
    sy  = (p1_r + dcik_pkg::HALF_ULP) >>> dcik_pkg::COEF_BITS;
    sny = (dcik_pkg::HALF_ULP - p1_r) >>> dcik_pkg::COEF_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r[0] <= dcik_pkg::D_W'(ka - xe);
      dy2_r[0] <= dcik_pkg::D_W'(41'sd0 - ye);
      dx2_r[1] <= dcik_pkg::D_W'(hx - xe);
      dy2_r[1] <= dcik_pkg::D_W'(sy - ye);
      dx2_r[2] <= dcik_pkg::D_W'(hx - xe);
      dy2_r[2] <= dcik_pkg::D_W'(sny - ye);
      zs2_r    <= zs1_r;
    end
  end

  // stage 3
  logic                             v3_r;
  logic [dcik_pkg::SQ_W-1:0]        sqx3_r [dcik_pkg::NTWR];
  logic [dcik_pkg::SQ_W-1:0]        sqy3_r [dcik_pkg::NTWR];
  logic [dcik_pkg::RAD_W-1:0]       l2_3_r;
  logic signed [dcik_pkg::ZS_W-1:0] zs3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < dcik_pkg::NTWR; t++) begin
        sqx3_r[t] <= dcik_pkg::SQ_W'(dx2_r[t] * dx2_r[t]);
        sqy3_r[t] <= dcik_pkg::SQ_W'(dy2_r[t] * dy2_r[t]);
      end
      l2_3_r <= cfg.arm * cfg.arm;
      zs3_r  <= zs2_r;
    end
  end

  // stage 4
  logic                        v4_r;
  logic [dcik_pkg::RAD_W-1:0]  rad4_r [dcik_pkg::NTWR];
  dcik_pkg::side_t             side4_r;
  logic [dcik_pkg::D2_W-1:0]   d2 [dcik_pkg::NTWR];
  logic [dcik_pkg::NTWR-1:0]   far;

  always_comb begin
    for (int t = 0; t < dcik_pkg::NTWR; t++) begin
      d2[t]  = {1'b0, sqx3_r[t]} + {1'b0, sqy3_r[t]};
      far[t] = dcik_pkg::D2_W'(l2_3_r) < d2[t];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < dcik_pkg::NTWR; t++) begin
        rad4_r[t] <= far[t] ? '0 : l2_3_r - d2[t][dcik_pkg::RAD_W-1:0];
      end
      side4_r.zsum <= zs3_r;
      side4_r.mask <= far;
    end
  end

  assign v_out    = v4_r;
  assign rad_out  = rad4_r;
  assign side_out = side4_r;

endmodule

// ----- sv/dcik_sqrt.sv -----
// ----------------------------------------------------------------------------
// dcik_sqrt
// Three-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dcik_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        v_in,
  input  logic [dcik_pkg::RAD_W-1:0]  rad_in [dcik_pkg::NTWR],
  input  dcik_pkg::side_t             side_in,
  output logic                        v_out,
  output logic [dcik_pkg::LEN_W-1:0]  root_out [dcik_pkg::NTWR],
  output dcik_pkg::side_t             side_out
);

  localparam int N = dcik_pkg::NSTG;

  logic                        v_r    [N];
  dcik_pkg::side_t             side_r [N];
  logic [dcik_pkg::REM_W-1:0]  rem_r  [N][dcik_pkg::NTWR];
  logic [dcik_pkg::LEN_W-1:0]  root_r [N][dcik_pkg::NTWR];
  logic [dcik_pkg::RAD_W-1:0]  rad_r  [N][dcik_pkg::NTWR];

  logic [dcik_pkg::REM_W-1:0]  rem_nxt  [N][dcik_pkg::NTWR];
  logic [dcik_pkg::LEN_W-1:0]  root_nxt [N][dcik_pkg::NTWR];
  logic [dcik_pkg::RAD_W-1:0]  rad_nxt  [N][dcik_pkg::NTWR];

  always_comb begin
    logic [dcik_pkg::REM_W-1:0] rem_i, sh, trial;
    logic [dcik_pkg::LEN_W-1:0] root_i;
    logic [dcik_pkg::RAD_W-1:0] rad_i;
    for (int s = 0; s < N; s++) begin
      for (int t = 0; t < dcik_pkg::NTWR; t++) begin
        rem_i  = (s == 0) ? '0 : rem_r[(s == 0) ? 0 : s-1][t];
        root_i = (s == 0) ? '0 : root_r[(s == 0) ? 0 : s-1][t];
        rad_i  = (s == 0) ? rad_in[t] : rad_r[(s == 0) ? 0 : s-1][t];
        sh     = {rem_i[dcik_pkg::REM_W-3:0], rad_i[dcik_pkg::RAD_W-1 -: 2]};
        trial  = dcik_pkg::REM_W'({root_i, 2'b01});
        if (sh >= trial) begin
          rem_nxt[s][t]  = sh - trial;
          root_nxt[s][t] = {root_i[dcik_pkg::LEN_W-2:0], 1'b1};
        end else begin
          rem_nxt[s][t]  = sh;
          root_nxt[s][t] = {root_i[dcik_pkg::LEN_W-2:0], 1'b0};
        end
        rad_nxt[s][t] = {rad_i[dcik_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < N; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int s = 1; s < N; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int s = 1; s < N; s++) side_r[s] <= side_r[s-1];
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign v_out    = v_r[N-1];
  assign side_out = side_r[N-1];
  assign root_out = root_r[N-1];

endmodule

// ----- sv/dcik_back.sv -----
// ----------------------------------------------------------------------------
// dcik_back
// Carriage height, saturation and the output register.
// ----------------------------------------------------------------------------
module dcik_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic [dcik_pkg::LEN_W-1:0]         height,
  input  logic                               v_in,
  input  logic [dcik_pkg::LEN_W-1:0]         root_in [dcik_pkg::NTWR],
  input  dcik_pkg::side_t                    side_in,
  output logic                               v_out,
  output logic signed [dcik_pkg::POS_W-1:0]  h_out [dcik_pkg::NTWR],
  output logic [dcik_pkg::NTWR-1:0]          mask_out
);

  logic                              v_r;
  logic signed [dcik_pkg::POS_W-1:0] h_r [dcik_pkg::NTWR];
  logic [dcik_pkg::NTWR-1:0]         mask_r;
  logic signed [dcik_pkg::POS_W-1:0] h_nxt [dcik_pkg::NTWR];

  always_comb begin
    logic signed [dcik_pkg::H_W-1:0] hv;
    for (int t = 0; t < dcik_pkg::NTWR; t++) begin
      hv = $signed({5'd0, height})
         - ($signed({{2{side_in.zsum[dcik_pkg::ZS_W-1]}}, side_in.zsum})
            + $signed({5'd0, root_in[t]}));
      if (side_in.mask[t])
        h_nxt[t] = '0;
      else if (hv > $signed(dcik_pkg::H_W'(dcik_pkg::OUT_MAX)))
        h_nxt[t] = dcik_pkg::OUT_MAX;
      else if (hv < $signed(dcik_pkg::H_W'(dcik_pkg::OUT_MIN)))
        h_nxt[t] = dcik_pkg::OUT_MIN;
      else
        h_nxt[t] = hv[dcik_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= v_in;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r    <= h_nxt;
      mask_r <= side_in.mask;
    end
  end

  assign v_out    = v_r;
  assign h_out    = h_r;
  assign mask_out = mask_r;

endmodule

// ----- sv/delta_carriage_inverse_kinematics.sv -----
// ----------------------------------------------------------------------------
// delta_carriage_inverse_kinematics
// Effector position to three carriage heights of a linear delta robot.
// ----------------------------------------------------------------------------
// Input channel in_*: one beat carries pos_x, pos_y, pos_z (signed, 1/256 mm).
// Output channel out_*: one beat per input beat, in order, with carriage_a/b/c
// and unreachable_mask; an unreachable tower reads 0 and sets its mask bit.
// Geometry registers sit on the APB port (psel/penable/pwrite/paddr/pwdata),
// register i at byte address 4*i; pready is always high. Write them only
// while the pipeline is empty.
// Four front stages (offsets, deltas, squares, reach test), 22 square root
// stages at one root bit each, one output stage. Throughput is one beat per
// cycle unless stalled. The whole pipeline advances together;
// in_stall is high exactly when the output holds a beat that is stalled, so
// a stall freezes every stage and nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module delta_carriage_inverse_kinematics (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [dcik_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [dcik_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [dcik_pkg::POS_W-1:0]  in_pos_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dcik_pkg::POS_W-1:0]  out_carriage_a,
  output logic signed [dcik_pkg::POS_W-1:0]  out_carriage_b,
  output logic signed [dcik_pkg::POS_W-1:0]  out_carriage_c,
  output logic [dcik_pkg::NTWR-1:0]          out_unreachable_mask,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dcik_pkg::ADDR_W-1:0]        paddr,
  input  logic [dcik_pkg::DATA_W-1:0]        pwdata,
  output logic [dcik_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  dcik_pkg::cfg_t cfg;
  logic en;
  logic v_f, v_s;
  logic [dcik_pkg::RAD_W-1:0] rad [dcik_pkg::NTWR];
  logic [dcik_pkg::LEN_W-1:0] root [dcik_pkg::NTWR];
  dcik_pkg::side_t side_f, side_s;
  logic signed [dcik_pkg::POS_W-1:0] h [dcik_pkg::NTWR];

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  dcik_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  dcik_front u_front (
    .clk, .rst_n, .en, .cfg,
    .v_in(in_valid), .x_in(in_pos_x), .y_in(in_pos_y), .z_in(in_pos_z),
    .v_out(v_f), .rad_out(rad), .side_out(side_f)
  );

  dcik_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .v_in(v_f), .rad_in(rad), .side_in(side_f),
    .v_out(v_s), .root_out(root), .side_out(side_s)
  );

  dcik_back u_back (
    .clk, .rst_n, .en, .height(cfg.height),
    .v_in(v_s), .root_in(root), .side_in(side_s),
    .v_out(out_valid), .h_out(h), .mask_out(out_unreachable_mask)
  );

  assign out_carriage_a = h[0];
  assign out_carriage_b = h[1];
  assign out_carriage_c = h[2];

`ifndef SYNTHESIS
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_far_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unreachable_mask[0] |-> out_carriage_a == '0)
    else $error("unreachable tower A not zero");

  a_far_zero_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unreachable_mask[1] |-> out_carriage_b == '0)
    else $error("unreachable tower B not zero");
`endif

endmodule

// ----- dv/delta_carriage_inverse_kinematics_test.sv -----
// ----------------------------------------------------------------------------
// delta_carriage_inverse_kinematics_test
// Drives effector positions through the inverse kinematics block under random
// idling on both sides and checks every result beat against a built-in
// fixed point predictor. Geometry registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module delta_carriage_inverse_kinematics_test;

  localparam int LATENCY = 27;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [dcik_pkg::POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [dcik_pkg::POS_W-1:0] out_carriage_a, out_carriage_b, out_carriage_c;
  logic [dcik_pkg::NTWR-1:0] out_unreachable_mask;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [dcik_pkg::ADDR_W-1:0] paddr = '0;
  logic [dcik_pkg::DATA_W-1:0] pwdata = '0;
  logic [dcik_pkg::DATA_W-1:0] prdata;
  logic pready;

  typedef struct packed {
    logic signed [dcik_pkg::POS_W-1:0] a, b, c;
    logic [dcik_pkg::NTWR-1:0] mask;
  } heights_t;

  heights_t pending_heights[$];
  int errors = 0;
  longint cycles = 0;
  bit idle_on = 1'b1;

  longint arm_len, tower_h, plat_r, base_r, z_offset;

  delta_carriage_inverse_kinematics uut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** delta_carriage_inverse_kinematics: FAILED **");
      $finish;
    end
  end

  function automatic longint round_q16(longint v);
    longint s;
    s = v + 32768;
    if (s >= 0) return s >>> 16;
    return -((-s + 65535) >>> 16);
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic bit carriage_height(longint ox, longint oy, longint x, longint y,
                                         longint z,
                                         output logic signed [dcik_pkg::POS_W-1:0] h);
    longint dx, dy, d2, l2, v;
    dx = ox - x;
    dy = oy - y;
    d2 = dx * dx + dy * dy;
    l2 = arm_len * arm_len;
    if (l2 < d2) begin
      h = '0;
      return 1'b0;
    end
    v = tower_h - (z + z_offset + root_floor(l2 - d2));
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    h = v[dcik_pkg::POS_W-1:0];
    return 1'b1;
  endfunction

  function automatic heights_t predict_heights(logic signed [dcik_pkg::POS_W-1:0] px,
                                               logic signed [dcik_pkg::POS_W-1:0] py,
                                               logic signed [dcik_pkg::POS_W-1:0] pz);
    heights_t r;
    longint k, hx, sy, sny;
    k = base_r - plat_r;
    hx = round_q16(k * -32768);
    sy = round_q16(k * 56754);
    sny = round_q16(k * -56754);
    r.mask = '0;
    if (!carriage_height(k, 0, px, py, pz, r.a)) r.mask[0] = 1'b1;
    if (!carriage_height(hx, sy, px, py, pz, r.b)) r.mask[1] = 1'b1;
    if (!carriage_height(hx, sny, px, py, pz, r.c)) r.mask[2] = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n) out_stall <= idle_on ? ($urandom_range(99) < 38) : 1'b0;
  end

  always @(posedge clk) begin
    heights_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: unexpected beat a=%0d b=%0d c=%0d m=%0d", $time,
                 out_carriage_a, out_carriage_b, out_carriage_c, out_unreachable_mask);
        errors++;
      end else begin
        e = pending_heights.pop_front();
        if (out_carriage_a !== e.a) begin
          $display("%0t: carriage_a exp %0d got %0d", $time, e.a, out_carriage_a);
          errors++;
        end
        if (out_carriage_b !== e.b) begin
          $display("%0t: carriage_b exp %0d got %0d", $time, e.b, out_carriage_b);
          errors++;
        end
        if (out_carriage_c !== e.c) begin
          $display("%0t: carriage_c exp %0d got %0d", $time, e.c, out_carriage_c);
          errors++;
        end
        if (out_unreachable_mask !== e.mask) begin
          $display("%0t: mask exp %0d got %0d", $time, e.mask, out_unreachable_mask);
          errors++;
        end
      end
    end
  end

  task automatic send_position(logic signed [dcik_pkg::POS_W-1:0] px,
                               logic signed [dcik_pkg::POS_W-1:0] py,
                               logic signed [dcik_pkg::POS_W-1:0] pz);
    while (idle_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_heights.push_back(predict_heights(px, py, pz));
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_heights.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, longint value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= dcik_pkg::ADDR_W'(idx) << 2;
    pwdata <= dcik_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      dcik_pkg::REG_ARM:    arm_len = value & 22'h3FFFFF;
      dcik_pkg::REG_HEIGHT: tower_h = value & 22'h3FFFFF;
      dcik_pkg::REG_PLAT:   plat_r = value & 22'h3FFFFF;
      dcik_pkg::REG_BASE:   base_r = value & 22'h3FFFFF;
      dcik_pkg::REG_OFFSET: z_offset = longint'($signed(22'(value)));
      default: ;
    endcase
  endtask

  task automatic set_geometry(longint arm, longint ht, longint pr, longint br, longint off);
    drain_pipeline();
    write_reg(dcik_pkg::REG_ARM, arm);
    write_reg(dcik_pkg::REG_HEIGHT, ht);
    write_reg(dcik_pkg::REG_PLAT, pr);
    write_reg(dcik_pkg::REG_BASE, br);
    write_reg(dcik_pkg::REG_OFFSET, off);
  endtask

  function automatic logic signed [dcik_pkg::POS_W-1:0] rand_coord(int span);
    int r;
    r = $urandom_range(2 * span) - span;
    return r[dcik_pkg::POS_W-1:0];
  endfunction

  task automatic test_reset_defaults();
    send_position(0, 0, 0);
    send_position(58880, 0, 0);
    send_position(0, 0, 24'sh7FFFFF);
  endtask

  task automatic test_extremes();
    set_geometry(22'h3FFFFF, 22'h3FFFFF, 0, 22'h3FFFFF, -2097152);
    send_position(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_position(24'sh800000, 24'sh800000, 24'sh800000);
    send_position(24'sh7FFFFF, 24'sh800000, 0);
    send_position(0, 0, 24'sh800000);
    send_position(-1, -1, -1);
    set_geometry(1000, 0, 22'h3FFFFF, 0, 2097151);
    send_position(0, 0, 24'sh7FFFFF);
    send_position(24'sh800000, 0, 24'sh800000);
    send_position(24'sh5AAAAA, 24'shA55555, 24'sh555555);
    // arm exactly at reach: tower A at (300,0), arm 500, dx=300 dy=-400
    set_geometry(500, 100, 0, 300, 0);
    send_position(0, 400, 7);
    send_position(0, 401, 7);
  endtask

  task automatic random_phase(int n, int span, int zspan);
    for (int i = 0; i < n; i++)
      send_position(rand_coord(span), rand_coord(span), rand_coord(zspan));
  endtask

  task automatic test_random_geometries();
    set_geometry(58880, 90000, 5000, 40000, -3000);
    random_phase(450, 60000, 200000);
    // wait for the pipeline to empty mid-phase, then resume
    in_valid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk);
    random_phase(50, 60000, 200000);
    set_geometry($urandom_range(22'h3FFFFF), $urandom_range(22'h3FFFFF),
                 $urandom_range(22'h3FFFFF), $urandom_range(22'h3FFFFF),
                 $urandom_range(22'h3FFFFF));
    random_phase(300, 8388607, 8388607);
    idle_on = 1'b0;
    set_geometry(200000, 4000000, 30000, 100000, 1000000);
    random_phase(300, 300000, 8388607);
    idle_on = 1'b1;
    set_geometry(22'h3FFFFF, 0, 22'h3FFFFF, 22'h3FFFFF, -2097152);
    random_phase(350, 8388607, 8388607);
    set_geometry(58880, 0, 0, 0, 0);
    random_phase(380, 70000, 8388607);
  endtask

  initial begin
    arm_len = 58880;
    tower_h = 0;
    plat_r = 0;
    base_r = 0;
    z_offset = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_random_geometries();
    drain_pipeline();
    if (errors == 0) begin
      $display("** delta_carriage_inverse_kinematics: PASSED **");
    end else begin
      $display("** delta_carriage_inverse_kinematics: FAILED **");
    end
    $finish;
  end
endmodule

// ----- files.f -----
sv/dcik_pkg.sv
sv/dcik_cfg.sv
sv/dcik_front.sv
sv/dcik_sqrt.sv
sv/dcik_back.sv
sv/delta_carriage_inverse_kinematics.sv
dv/delta_carriage_inverse_kinematics_test.sv
